[hdl/http_request_length_scanner_defines.svh]
// ----------------------------------------------------------------------------
// HTTP request length scanner: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LENGTH_SCANNER_DEFINES_SVH
`define HTTP_REQUEST_LENGTH_SCANNER_DEFINES_SVH

// same-cycle implication
`define HRLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hrls_pkg.sv]
// ----------------------------------------------------------------------------
// hrls_pkg
// Types, state codes, status codes and the header name pattern of the
// HTTP request length scanner.
// ----------------------------------------------------------------------------
package hrls_pkg;

  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned OUT_W           = 32;
  localparam int unsigned STATE_W         = 5;
  localparam int unsigned STATUS_W        = 4;
  localparam int unsigned NAME_LEN        = 15;
  localparam int unsigned NAME_IDX_W      = 4;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_C     = 8'h63;

  // status codes
  localparam logic [STATUS_W-1:0] ST_SCAN     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DONE     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_DUP_LEN  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PRE  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_DIG  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NOLF_LEN = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NOLF_TXT = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NOLF_BLK = 4'd7;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd8;

  // scan state codes
  localparam logic [STATE_W-1:0] S_REQ      = 5'd0;
  localparam logic [STATE_W-1:0] S_REQ_CR   = 5'd1;
  localparam logic [STATE_W-1:0] S_NAME     = 5'd2;
  localparam logic [STATE_W-1:0] S_NAME_END = 5'd16;
  localparam logic [STATE_W-1:0] S_SPACES   = 5'd17;
  localparam logic [STATE_W-1:0] S_DIGITS   = 5'd18;
  localparam logic [STATE_W-1:0] S_LEN_CR   = 5'd19;
  localparam logic [STATE_W-1:0] S_TEXT     = 5'd20;
  localparam logic [STATE_W-1:0] S_TEXT_CR  = 5'd21;
  localparam logic [STATE_W-1:0] S_LINE     = 5'd22;
  localparam logic [STATE_W-1:0] S_BLANK_CR = 5'd23;
  localparam logic [STATE_W-1:0] S_TERM     = 5'd23;
  localparam logic [STATE_W-1:0] S_FIN_OK   = 5'd24;
  localparam logic [STATE_W-1:0] S_FIN_DUP  = 5'd25;
  localparam logic [STATE_W-1:0] S_FIN_PRE  = 5'd26;
  localparam logic [STATE_W-1:0] S_FIN_DIG  = 5'd27;
  localparam logic [STATE_W-1:0] S_FIN_LEN  = 5'd28;
  localparam logic [STATE_W-1:0] S_FIN_TXT  = 5'd29;
  localparam logic [STATE_W-1:0] S_FIN_BLK  = 5'd30;
  localparam logic [STATE_W-1:0] S_FIN_OVF  = 5'd31;

  // "content-length:" in lower case
  localparam logic [7:0] NAME_PAT [NAME_LEN] = '{
    8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
    8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } hrls_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    total_length;
    logic [OUT_W-1:0]    body_length;
  } hrls_out_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b | 8'h20;
    end
    return r;
  endfunction

endpackage

[hdl/hrls_step.sv]
// ----------------------------------------------------------------------------
// hrls_step
// Next-state logic of the scanner for one request byte: name match,
// length accumulation with overflow check, line tracking.
// ----------------------------------------------------------------------------
module hrls_step #(
  parameter int unsigned COUNT_WIDTH = hrls_pkg::DEF_COUNT_WIDTH
) (
  input  logic [hrls_pkg::STATE_W-1:0] state_i,
  input  logic [COUNT_WIDTH-1:0]       len_i,
  input  logic [COUNT_WIDTH-1:0]       hdr_i,
  input  logic [hrls_pkg::OUT_W-1:0]   total_i,
  input  logic [7:0]                   data_i,
  output logic [hrls_pkg::STATE_W-1:0] state_o,
  output logic [COUNT_WIDTH-1:0]       len_o,
  output logic [COUNT_WIDTH-1:0]       hdr_o,
  output logic [hrls_pkg::OUT_W-1:0]   total_o
);

  logic                               digit;
  logic [3:0]                         dval;
  logic [7:0]                         folded;
  logic                               in_name;
  logic [hrls_pkg::NAME_IDX_W-1:0]    name_idx;
  logic [hrls_pkg::STATE_W-1:0]       name_off;
  logic [COUNT_WIDTH+3:0]             prod;
  logic [COUNT_WIDTH:0]               sum;

  assign digit    = (data_i >= 8'h30) && (data_i <= 8'h39);
  assign dval     = data_i[3:0];
  assign folded   = hrls_pkg::fold(data_i);
  assign in_name  = (state_i >= hrls_pkg::S_NAME) && (state_i <= hrls_pkg::S_NAME_END);
  assign name_off = state_i - hrls_pkg::S_NAME;
  assign name_idx = name_off[hrls_pkg::NAME_IDX_W-1:0];

  // len * 10 + d, top four bits flag overflow
  assign prod = ({4'b0000, len_i} << 3) + ({4'b0000, len_i} << 1)
              + (COUNT_WIDTH+4)'(dval);
  // header bytes up to and including this one plus length
  assign sum  = {1'b0, hdr_i} + {1'b0, len_i} + (COUNT_WIDTH+1)'(1);

  always_comb begin
    state_o = state_i;
    len_o   = len_i;
    hdr_o   = hdr_i;
    total_o = total_i;
    if (state_i <= hrls_pkg::S_TERM) begin
      if (&hdr_i) begin
        state_o = hrls_pkg::S_FIN_OVF;
      end else begin
        hdr_o = hdr_i + COUNT_WIDTH'(1);
        if (in_name) begin
          if (folded == hrls_pkg::NAME_PAT[name_idx]) begin
            state_o = (name_idx == hrls_pkg::NAME_IDX_W'(hrls_pkg::NAME_LEN - 1))
                    ? hrls_pkg::S_SPACES : state_i + hrls_pkg::STATE_W'(1);
          end else begin
            state_o = (data_i == hrls_pkg::CHAR_CR) ? hrls_pkg::S_TEXT_CR
                                                    : hrls_pkg::S_TEXT;
          end
        end else begin
          case (state_i)
            hrls_pkg::S_REQ: begin
              if (data_i == hrls_pkg::CHAR_CR) state_o = hrls_pkg::S_REQ_CR;
            end
            hrls_pkg::S_REQ_CR: begin
              state_o = (data_i == hrls_pkg::CHAR_LF) ? hrls_pkg::S_NAME : hrls_pkg::S_REQ;
            end
            hrls_pkg::S_SPACES: begin
              if (digit) begin
                if (len_i != '0) begin
                  state_o = hrls_pkg::S_FIN_DUP;
                end else begin
                  len_o   = COUNT_WIDTH'(dval);
                  state_o = hrls_pkg::S_DIGITS;
                end
              end else if (data_i != hrls_pkg::CHAR_SPACE) begin
                state_o = hrls_pkg::S_FIN_PRE;
              end
            end
            hrls_pkg::S_DIGITS: begin
              if (digit) begin
                if (prod[COUNT_WIDTH+3:COUNT_WIDTH] != 4'b0000) begin
                  state_o = hrls_pkg::S_FIN_OVF;
                end else begin
                  len_o = prod[COUNT_WIDTH-1:0];
                end
              end else if (data_i == hrls_pkg::CHAR_CR) begin
                state_o = hrls_pkg::S_LEN_CR;
              end else begin
                state_o = hrls_pkg::S_FIN_DIG;
              end
            end
            hrls_pkg::S_LEN_CR: begin
              state_o = (data_i == hrls_pkg::CHAR_LF) ? hrls_pkg::S_LINE
                                                      : hrls_pkg::S_FIN_LEN;
            end
            hrls_pkg::S_TEXT: begin
              state_o = (data_i == hrls_pkg::CHAR_CR) ? hrls_pkg::S_TEXT_CR
                                                      : hrls_pkg::S_TEXT;
            end
            hrls_pkg::S_TEXT_CR: begin
              state_o = (data_i == hrls_pkg::CHAR_LF) ? hrls_pkg::S_LINE
                                                      : hrls_pkg::S_FIN_TXT;
            end
            hrls_pkg::S_LINE: begin
              if (data_i == hrls_pkg::CHAR_CR) begin
                state_o = hrls_pkg::S_BLANK_CR;
              end else if (folded == hrls_pkg::CHAR_C) begin
                state_o = hrls_pkg::S_NAME + hrls_pkg::STATE_W'(1);
              end else begin
                state_o = hrls_pkg::S_TEXT;
              end
            end
            hrls_pkg::S_BLANK_CR: begin
              if (data_i != hrls_pkg::CHAR_LF) begin
                state_o = hrls_pkg::S_FIN_BLK;
              end else if (sum[COUNT_WIDTH]) begin
                state_o = hrls_pkg::S_FIN_OVF;
              end else begin
                state_o = hrls_pkg::S_FIN_OK;
                total_o = hrls_pkg::OUT_W'(sum[COUNT_WIDTH-1:0]);
              end
            end
            default: begin
              state_o = state_i;
            end
          endcase
        end
      end
    end
  end

endmodule

[hdl/http_request_length_scanner.sv]
// ----------------------------------------------------------------------------
// http_request_length_scanner
// Scans an HTTP request one byte per word and reports header plus body length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one request byte
//   per word; restart = 1 begins a new request with that byte.
//   Output channel (out_valid_o / out_stall_i / out_word_o) gives one result
//   word per input word: status, total_length (valid when status is complete)
//   and body_length.
//   A word accepted into the input register is scanned from there and its
//   result is registered in the result register.
//   Throughput: one word per cycle while the receiver does not stall, set by
//   the single scan-state loop (next state, length multiply-add, byte count)
//   between input and result registers.
//   Reset clears the scan state and counters and empties both registers.
//   When the receiver stalls, the result register holds; a word is taken into
//   the input register only while it is empty, then in_stall_o rises.
//   A final status repeats until a word with restart set arrives.
// ----------------------------------------------------------------------------
`include "http_request_length_scanner_defines.svh"

module http_request_length_scanner #(
  parameter int unsigned COUNT_WIDTH = hrls_pkg::DEF_COUNT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hrls_pkg::hrls_in_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hrls_pkg::hrls_out_t out_word_o
);

  logic                         in_valid_q, in_valid_d;
  hrls_pkg::hrls_in_t           in_word_q;
  logic                         out_valid_q, out_valid_d;
  hrls_pkg::hrls_out_t          out_word_q, out_word_d;

  logic [hrls_pkg::STATE_W-1:0] state_q, state_d, state_eff;
  logic [COUNT_WIDTH-1:0]       len_q, len_d, len_eff;
  logic [COUNT_WIDTH-1:0]       hdr_q, hdr_d, hdr_eff;
  logic [hrls_pkg::OUT_W-1:0]   total_q, total_d;
  logic [hrls_pkg::STATE_W-1:0] status_off;

  logic accept;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign state_eff = in_word_q.restart ? hrls_pkg::S_REQ : state_q;
  assign len_eff   = in_word_q.restart ? '0 : len_q;
  assign hdr_eff   = in_word_q.restart ? '0 : hdr_q;

  hrls_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .state_i (state_eff),
    .len_i   (len_eff),
    .hdr_i   (hdr_eff),
    .total_i (total_q),
    .data_i  (in_word_q.data_byte),
    .state_o (state_d),
    .len_o   (len_d),
    .hdr_o   (hdr_d),
    .total_o (total_d)
  );

  assign status_off = state_d - hrls_pkg::S_TERM;

  always_comb begin
    out_word_d.body_length = hrls_pkg::OUT_W'(len_d);
    if (state_d > hrls_pkg::S_TERM) begin
      out_word_d.status = status_off[hrls_pkg::STATUS_W-1:0];
    end else begin
      out_word_d.status = hrls_pkg::ST_SCAN;
    end
    out_word_d.total_length = (state_d == hrls_pkg::S_FIN_OK) ? total_d : '0;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= hrls_pkg::S_REQ;
      len_q       <= '0;
      hdr_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
        len_q   <= len_d;
        hdr_q   <= hdr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
      total_q    <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `HRLS_ASSERT_NOW(a_total_only_done, out_valid_q && (out_word_q.status != hrls_pkg::ST_DONE), out_word_q.total_length == '0, "total length set without complete status")
  `HRLS_ASSERT_NOW(a_status_range, out_valid_q, out_word_q.status <= hrls_pkg::ST_OVERFLOW, "status code out of range")
  `HRLS_ASSERT_NXT(a_final_sticky, advance && !in_word_q.restart && (state_q > hrls_pkg::S_TERM), state_q == $past(state_q), "final status changed without restart")
  `HRLS_ASSERT_NXT(a_advance_shows, advance, out_valid_q, "advanced word not shown at output")

endmodule
